// File: hdl/strided_range_set_matcher_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the strided range set matcher
// Shared property forms used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef STRIDED_RANGE_SET_MATCHER_CORE_DEFINES_SVH
`define STRIDED_RANGE_SET_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, off during reset
`define SRSM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srsm: same-cycle check failed");

// Next-cycle implication, off during reset
`define SRSM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srsm: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define SRSM_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srsm: reset check failed");

`endif

// File: hdl/srsm_pkg.sv
// ---------------------------------------------------------------------------
// srsm_pkg
// Types and constants of the strided range set matcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srsm_pkg;

  // Field widths
  localparam int VAL_W    = 32;
  localparam int STRIDE_W = 16;
  localparam int REQ_W    = 3;
  localparam int GRP_W    = 6;
  // Remainder unit: one extra bit for distances up to 2^VAL_W
  localparam int DIVD_W   = VAL_W + 1;
  localparam int STEP_W   = $clog2(DIVD_W + 1);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DROP   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ALL    = 3'd4;

  // Control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DROP_UPD,
    ST_MOD_WAIT,
    ST_FINISH
  } srsm_state_t;

  // One table entry, with the running bounds of entries 0..this one
  typedef struct packed {
    logic [VAL_W-1:0]    lower;
    logic [VAL_W-1:0]    upper;
    logic [STRIDE_W-1:0] stride;
    logic [VAL_W-1:0]    lo_min;
    logic [VAL_W-1:0]    hi_max;
  } srsm_entry_t;

  // Status of the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } srsm_mod_sts_t;

endpackage

`default_nettype wire

// File: hdl/srsm_if.sv
// ---------------------------------------------------------------------------
// srsm_req_if / srsm_rsp_if
// Valid/ready channels carrying request and response words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface srsm_req_if;
  import srsm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] operand_value;
  logic signed [VAL_W-1:0] upper_value;
  logic [STRIDE_W-1:0]     step_value;

  modport source (output valid, req_type, operand_value, upper_value, step_value,
                  input ready);
  modport sink   (input valid, req_type, operand_value, upper_value, step_value,
                  output ready);
endinterface

interface srsm_rsp_if;
  import srsm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    selected;
  logic signed [GRP_W-1:0] group_index;
  logic                    table_full;
  logic signed [VAL_W-1:0] lowest_bound;
  logic signed [VAL_W-1:0] highest_bound;

  modport source (output valid, selected, group_index, table_full, lowest_bound,
                  highest_bound, input ready);
  modport sink   (input valid, selected, group_index, table_full, lowest_bound,
                  highest_bound, output ready);
endinterface

`default_nettype wire

// File: hdl/srsm_mod.sv
// ---------------------------------------------------------------------------
// srsm_mod
// Bit-serial restoring remainder: tells whether a distance is a multiple
// of a 16-bit stride, one dividend bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsm_mod (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [srsm_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [srsm_pkg::STRIDE_W-1:0] divisor,
  output srsm_pkg::srsm_mod_sts_t            sts
);
  import srsm_pkg::*;

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   cnt;
  logic [DIVD_W-1:0]   quo;
  logic [STRIDE_W-1:0] dvs;
  logic [STRIDE_W-1:0] rem;
  logic [STRIDE_W-1:0] rem_next;
  logic [STRIDE_W:0]   trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quo[DIVD_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = STRIDE_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = STRIDE_W'(trial);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign sts.done     = done;
  assign sts.rem_zero = (rem == '0);

endmodule

`default_nettype wire

// File: hdl/strided_range_set_matcher_core.sv
// ---------------------------------------------------------------------------
// strided_range_set_matcher_core
// Ordered table of strided index ranges with query, append, drop, clear and
// all-mode requests; one response word per request word.
// ---------------------------------------------------------------------------
// Works on one request at a time; ready is high only while idle, and a
// finished response waits in an output register, so the next request is
// taken while the previous response is still pending. A query in table
// mode reads the single-port entry memory one entry at a time until the
// first range holding the value and, if one is found, then waits on the
// bit-serial remainder unit; an all-mode query goes straight to the
// remainder unit. Table bounds are kept as running min/max per entry, so
// a drop costs one memory read and no rescan. Entries beyond the fill
// count are never read, so the memory needs no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module strided_range_set_matcher_core #(
  parameter int MAX_RANGES = 16
) (
  input wire logic clk,
  input wire logic rst,
  srsm_req_if.sink   req,
  srsm_rsp_if.source rsp
);
  import srsm_pkg::*;

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  // Control state
  srsm_state_t         state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                all_mode, all_mode_next;
  logic [STRIDE_W-1:0] gstride, gstride_next;
  logic [CNT_W-1:0]    scan_idx, scan_idx_next;
  logic                rsp_valid, rsp_valid_next;

  // Running table bounds
  logic [VAL_W-1:0]    bound_lo, bound_lo_next;
  logic [VAL_W-1:0]    bound_hi, bound_hi_next;

  // Latched request word
  logic [REQ_W-1:0]    rtype;
  logic [VAL_W-1:0]    val;
  logic [VAL_W-1:0]    up;
  logic [STRIDE_W-1:0] st;

  // Working result and response register
  logic                res_sel, res_sel_next;
  logic [GRP_W-1:0]    res_grp, res_grp_next;
  logic                res_full, res_full_next;
  logic                out_sel;
  logic [GRP_W-1:0]    out_grp;
  logic                out_full;
  logic [VAL_W-1:0]    out_lo;
  logic [VAL_W-1:0]    out_hi;
  logic                load_out;

  // Entry memory
  srsm_entry_t         mem [MAX_RANGES];
  srsm_entry_t         rd_data;
  srsm_entry_t         wr_data;
  logic                mem_we;
  logic                mem_re;
  logic [IDX_W-1:0]    rd_addr;

  // Remainder unit
  logic                mod_start;
  logic [DIVD_W-1:0]   mod_dividend;
  logic [STRIDE_W-1:0] mod_divisor;
  srsm_mod_sts_t       mod_sts;

  // Derived values
  logic [STRIDE_W-1:0] st_fixed;
  logic [DIVD_W-1:0]   val_ext;
  logic [DIVD_W-1:0]   val_mag;
  logic [DIVD_W-1:0]   delta;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    cnt_m2;
  logic                in_range;
  logic                table_has_room;
  logic [VAL_W-1:0]    app_lo;
  logic [VAL_W-1:0]    app_hi;

  assign st_fixed       = (st == '0) ? STRIDE_W'(1) : st;
  assign val_ext        = {val[VAL_W-1], val};
  assign val_mag        = val_ext[DIVD_W-1] ? (~val_ext + 1'b1) : val_ext;
  assign delta          = DIVD_W'({val[VAL_W-1], val} - {rd_data.lower[VAL_W-1],
                                  rd_data.lower} + 1'b1);
  assign cnt_m1         = count - 1'b1;
  assign cnt_m2         = count - CNT_W'(2);
  assign in_range       = ($signed(val) >= $signed(rd_data.lower)) &&
                          ($signed(val) <= $signed(rd_data.upper));
  assign table_has_room = (count < CNT_W'(MAX_RANGES));

  // Bounds after an append
  always_comb begin
    if (count == '0) begin
      app_lo = val;
      app_hi = up;
    end else begin
      app_lo = ($signed(val) < $signed(bound_lo)) ? val : bound_lo;
      app_hi = ($signed(up) > $signed(bound_hi)) ? up : bound_hi;
    end
  end

  assign wr_data.lower  = val;
  assign wr_data.upper  = up;
  assign wr_data.stride = st_fixed;
  assign wr_data.lo_min = app_lo;
  assign wr_data.hi_max = app_hi;

  // Next state and outputs
  always_comb begin
    state_next     = state;
    count_next     = count;
    all_mode_next  = all_mode;
    gstride_next   = gstride;
    scan_idx_next  = scan_idx;
    bound_lo_next  = bound_lo;
    bound_hi_next  = bound_hi;
    res_sel_next   = res_sel;
    res_grp_next   = res_grp;
    res_full_next  = res_full;
    rsp_valid_next = rsp_valid;
    load_out       = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    rd_addr        = scan_idx[IDX_W-1:0];
    mod_start      = 1'b0;
    mod_dividend   = delta;
    mod_divisor    = rd_data.stride;

    if (rsp_valid && rsp.ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          res_sel_next  = 1'b0;
          res_grp_next  = '0;
          res_full_next = 1'b0;
          state_next    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_FINISH;
        case (rtype)
          REQ_QUERY: begin
            if (all_mode) begin
              res_grp_next = '1;
              mod_start    = 1'b1;
              mod_dividend = val_mag;
              mod_divisor  = gstride;
              state_next   = ST_MOD_WAIT;
            end else if (count == '0) begin
              res_grp_next = '0;
            end else begin
              scan_idx_next = '0;
              state_next    = ST_SCAN_RD;
            end
          end
          REQ_APPEND: begin
            all_mode_next = 1'b0;
            if (table_has_room) begin
              mem_we        = 1'b1;
              count_next    = count + 1'b1;
              bound_lo_next = app_lo;
              bound_hi_next = app_hi;
            end else begin
              res_full_next = 1'b1;
            end
          end
          REQ_DROP: begin
            all_mode_next = 1'b0;
            if (count != '0) begin
              count_next = cnt_m1;
            end
            // New last entry holds the bounds of what remains
            if (count > CNT_W'(1)) begin
              mem_re     = 1'b1;
              rd_addr    = cnt_m2[IDX_W-1:0];
              state_next = ST_DROP_UPD;
            end
          end
          REQ_CLEAR: begin
            all_mode_next = 1'b0;
            gstride_next  = STRIDE_W'(1);
            count_next    = '0;
          end
          REQ_ALL: begin
            count_next    = '0;
            all_mode_next = 1'b1;
            gstride_next  = st_fixed;
          end
          default: begin
          end
        endcase
      end

      ST_SCAN_RD: begin
        mem_re     = 1'b1;
        state_next = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (in_range) begin
          res_grp_next = GRP_W'(scan_idx);
          mod_start    = 1'b1;
          state_next   = ST_MOD_WAIT;
        end else if (scan_idx == cnt_m1) begin
          res_grp_next = GRP_W'(count);
          state_next   = ST_FINISH;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end

      ST_DROP_UPD: begin
        bound_lo_next = rd_data.lo_min;
        bound_hi_next = rd_data.hi_max;
        state_next    = ST_FINISH;
      end

      ST_MOD_WAIT: begin
        if (mod_sts.done) begin
          res_sel_next = mod_sts.rem_zero;
          state_next   = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          load_out       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      all_mode  <= 1'b0;
      gstride   <= STRIDE_W'(1);
      scan_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      all_mode  <= all_mode_next;
      gstride   <= gstride_next;
      scan_idx  <= scan_idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bound_lo <= bound_lo_next;
    bound_hi <= bound_hi_next;
    res_sel  <= res_sel_next;
    res_grp  <= res_grp_next;
    res_full <= res_full_next;
    if (req.valid && req.ready) begin
      rtype <= req.req_type;
      val   <= req.operand_value;
      up    <= req.upper_value;
      st    <= req.step_value;
    end
    if (load_out) begin
      out_sel  <= res_sel;
      out_grp  <= res_grp;
      out_full <= res_full;
      out_lo   <= (count == '0) ? '1 : bound_lo;
      out_hi   <= (count == '0) ? '1 : bound_hi;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  srsm_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .sts      (mod_sts)
  );

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.selected      = out_sel;
  assign rsp.group_index   = out_grp;
  assign rsp.table_full    = out_full;
  assign rsp.lowest_bound  = out_lo;
  assign rsp.highest_bound = out_hi;

endmodule

`default_nettype wire

// File: hdl/srsm_checker.sv
// ---------------------------------------------------------------------------
// srsm_checker
// Port-level checks of the strided range set matcher, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "strided_range_set_matcher_core_defines.svh"

module srsm_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  req_valid,
  input wire logic                                  req_ready,
  input wire logic                                  rsp_valid,
  input wire logic                                  rsp_ready,
  input wire logic                                  selected,
  input wire logic signed [srsm_pkg::GRP_W-1:0]     group_index,
  input wire logic                                  table_full,
  input wire logic signed [srsm_pkg::VAL_W-1:0]     lowest_bound,
  input wire logic signed [srsm_pkg::VAL_W-1:0]     highest_bound
);
  import srsm_pkg::*;

  // Reset empties the response register
  `SRSM_ASSERT_RST(a_rst_no_rsp, clk, rst, !rsp_valid)

  // One request at a time: busy right after taking a word
  `SRSM_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // A stalled response holds
  `SRSM_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(selected) && $stable(group_index) &&
                   $stable(table_full) && $stable(lowest_bound) &&
                   $stable(highest_bound))

  // A dropped append is never a query result
  `SRSM_ASSERT_NOW(a_full_not_query, clk, rst, rsp_valid && table_full,
                   !selected && (group_index == '0))

endmodule

bind strided_range_set_matcher_core srsm_checker u_srsm_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .selected      (rsp.selected),
  .group_index   (rsp.group_index),
  .table_full    (rsp.table_full),
  .lowest_bound  (rsp.lowest_bound),
  .highest_bound (rsp.highest_bound)
);

`default_nettype wire
